// ===== sv/ltmcr_pkg.sv =====
// ----------------------------------------------------------------------------
// ltmcr_pkg
// Shared types and constants for the tile map character cell renderer.
// ----------------------------------------------------------------------------
package ltmcr_pkg;

  localparam int unsigned MAP_WIDTH      = 32;
  localparam int unsigned MAP_HEIGHT     = 32;
  localparam int unsigned SCREEN_COLUMNS = 40;
  localparam int unsigned SCREEN_ROWS    = 24;

  localparam int unsigned MAP_DEPTH   = 1024;
  localparam int unsigned TILE_DEPTH  = 4096;
  localparam int unsigned LIGHT_DEPTH = 1024;
  localparam int unsigned ATTR_DEPTH  = 1024;

  localparam int unsigned MAP_AW   = $clog2(MAP_DEPTH);
  localparam int unsigned TILE_AW  = $clog2(TILE_DEPTH);
  localparam int unsigned LIGHT_AW = $clog2(LIGHT_DEPTH);
  localparam int unsigned ATTR_AW  = $clog2(ATTR_DEPTH);

  localparam logic [7:0] SHIFT_BASE     = 8'hC0;
  localparam logic [2:0] MAX_LEVEL      = 3'd4;
  localparam logic [1:0] UNLIT_ATTR_SEL = 2'd2;
  localparam logic [7:0] MOONLIGHT_RST  = 8'd11;

  localparam int unsigned MIN_MAP_DIM = (MAP_WIDTH < MAP_HEIGHT) ? MAP_WIDTH : MAP_HEIGHT;
  localparam int unsigned WRAP_STEPS  = 63 / MIN_MAP_DIM;

  typedef enum logic [2:0] {
    MODE_RENDER = 3'd0,
    MODE_MAP    = 3'd1,
    MODE_TILE   = 3'd2,
    MODE_LIGHT  = 3'd3,
    MODE_ATTR   = 3'd4
  } mode_e;

  typedef enum logic [1:0] {
    REG_SCROLL_X  = 2'd0,
    REG_SCROLL_Y  = 2'd1,
    REG_MOONLIGHT = 2'd2
  } reg_idx_e;

  typedef struct packed {
    logic [6:0] scroll_x;
    logic [6:0] scroll_y;
    logic [7:0] moonlight_colour;
  } cfg_t;

  typedef struct packed {
    logic [2:0]  mode;
    logic [11:0] address;
    logic [7:0]  data;
    logic [5:0]  column;
    logic [4:0]  row;
  } item_t;

  typedef struct packed {
    logic [7:0] char_code;
    logic [7:0] colour;
  } result_t;

  function automatic logic [7:0] wrap_coord(input logic [5:0] v, input int unsigned m);
    logic [7:0] r;
    r = {2'b00, v};
    for (int i = 0; i < WRAP_STEPS; i++) begin
      if (r >= m) begin
        r = r - 8'(m);
      end
    end
    return r;
  endfunction

endpackage

// ===== sv/ltmcr_if.sv =====
// ----------------------------------------------------------------------------
// ltmcr_in_if / ltmcr_out_if
// Valid/ready channels for render and store-write items and for results.
// ----------------------------------------------------------------------------
interface ltmcr_in_if;
  logic        valid;
  logic        ready;
  logic [2:0]  mode;
  logic [11:0] address;
  logic [7:0]  data;
  logic [5:0]  column;
  logic [4:0]  row;

  modport source(output valid, output mode, output address, output data,
                 output column, output row, input ready);
  modport sink(input valid, input mode, input address, input data,
               input column, input row, output ready);
endinterface

interface ltmcr_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_code;
  logic [7:0] colour;

  modport source(output valid, output char_code, output colour, input ready);
  modport sink(input valid, input char_code, input colour, output ready);
endinterface

// ===== sv/ltmcr_pipe.sv =====
// ----------------------------------------------------------------------------
// ltmcr_pipe
// Three-stage memory pipeline: map/light read, tile read, attribute read into
// the result register. Store writes travel with the items and land in the stage
// that reads the same store, so item order is kept without forwarding.
// ----------------------------------------------------------------------------
module ltmcr_pipe (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  ltmcr_pkg::cfg_t   cfg_i,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  ltmcr_pkg::item_t  in_item_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output ltmcr_pkg::result_t out_item_o
);

  logic [7:0] map_mem   [ltmcr_pkg::MAP_DEPTH];
  logic [2:0] light_mem [ltmcr_pkg::LIGHT_DEPTH];
  logic [7:0] tile_mem  [ltmcr_pkg::TILE_DEPTH];
  logic [7:0] attr_mem  [ltmcr_pkg::ATTR_DEPTH];

  logic adv;
  logic in_fire;

  logic [7:0]  cx, cy, mx, my;
  logic [16:0] map_lin;
  logic [15:0] light_lin;
  logic [ltmcr_pkg::MAP_AW-1:0]   map_idx;
  logic [ltmcr_pkg::LIGHT_AW-1:0] light_idx;

  logic        s1_valid_q;
  logic [2:0]  s1_mode_q;
  logic [11:0] s1_addr_q;
  logic [7:0]  s1_data_q;
  logic [1:0]  s1_cx_lo_q, s1_cy_lo_q;
  logic [7:0]  map_rd_q;
  logic [2:0]  light_rd_q;
  logic [ltmcr_pkg::TILE_AW-1:0] tile_addr;

  logic        s2_valid_q;
  logic [2:0]  s2_mode_q;
  logic [ltmcr_pkg::ATTR_AW-1:0] s2_addr_q;
  logic [7:0]  s2_data_q;
  logic [2:0]  s2_level_q;
  logic [7:0]  tile_rd_q;

  logic [2:0]  lvl;
  logic        lit;
  logic        moon;
  logic [7:0]  ch_shift;
  logic [1:0]  attr_sel;
  logic [ltmcr_pkg::ATTR_AW-1:0] attr_idx;

  logic        s3_valid_q;
  logic [7:0]  s3_char_q;
  logic        s3_moon_q;
  logic [7:0]  attr_rd_q;

  assign adv        = !s3_valid_q || out_ready_i;
  assign in_ready_o = adv;
  assign in_fire    = in_valid_i && adv;

  // stage 0: scroll, wrap, map and light addresses
  always_comb begin
    cx        = {1'b0, cfg_i.scroll_x} + {2'b00, in_item_i.column};
    cy        = {1'b0, cfg_i.scroll_y} + {3'b000, in_item_i.row};
    mx        = ltmcr_pkg::wrap_coord(cx[7:2], ltmcr_pkg::MAP_WIDTH);
    my        = ltmcr_pkg::wrap_coord(cy[7:2], ltmcr_pkg::MAP_HEIGHT);
    map_lin   = 17'(my) * 17'(ltmcr_pkg::MAP_WIDTH) + 17'(mx);
    light_lin = 16'(in_item_i.row) * 16'(ltmcr_pkg::SCREEN_COLUMNS)
              + 16'(in_item_i.column);
    map_idx   = map_lin[ltmcr_pkg::MAP_AW-1:0];
    light_idx = light_lin[ltmcr_pkg::LIGHT_AW-1:0];
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      if (in_fire && in_item_i.mode == ltmcr_pkg::MODE_MAP) begin
        map_mem[in_item_i.address[ltmcr_pkg::MAP_AW-1:0]] <= in_item_i.data;
      end
      if (in_fire && in_item_i.mode == ltmcr_pkg::MODE_LIGHT) begin
        light_mem[in_item_i.address[ltmcr_pkg::LIGHT_AW-1:0]] <= in_item_i.data[2:0];
      end
      map_rd_q   <= map_mem[map_idx];
      light_rd_q <= light_mem[light_idx];
      s1_mode_q  <= in_item_i.mode;
      s1_addr_q  <= in_item_i.address;
      s1_data_q  <= in_item_i.data;
      s1_cx_lo_q <= cx[1:0];
      s1_cy_lo_q <= cy[1:0];
    end
  end

  // stage 1: tile table
  assign tile_addr = {map_rd_q, s1_cy_lo_q, s1_cx_lo_q};

  always_ff @(posedge clk_i) begin
    if (adv) begin
      if (s1_valid_q && s1_mode_q == ltmcr_pkg::MODE_TILE) begin
        tile_mem[s1_addr_q[ltmcr_pkg::TILE_AW-1:0]] <= s1_data_q;
      end
      tile_rd_q  <= tile_mem[tile_addr];
      s2_mode_q  <= s1_mode_q;
      s2_addr_q  <= s1_addr_q[ltmcr_pkg::ATTR_AW-1:0];
      s2_data_q  <= s1_data_q;
      s2_level_q <= light_rd_q;
    end
  end

  // stage 2: light and attribute table
  always_comb begin
    lvl      = (s2_level_q > ltmcr_pkg::MAX_LEVEL) ? ltmcr_pkg::MAX_LEVEL : s2_level_q;
    lit      = (cfg_i.scroll_x[1:0] == 2'd0);
    moon     = lit && (lvl == 3'd0);
    ch_shift = tile_rd_q;
    if (lit && lvl != 3'd0 && tile_rd_q >= ltmcr_pkg::SHIFT_BASE) begin
      ch_shift = tile_rd_q + {5'd0, lvl} - 8'd1;
    end
    attr_sel = lit ? 2'(lvl - 3'd1) : ltmcr_pkg::UNLIT_ATTR_SEL;
    attr_idx = {attr_sel, ch_shift};
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      if (s2_valid_q && s2_mode_q == ltmcr_pkg::MODE_ATTR) begin
        attr_mem[s2_addr_q] <= s2_data_q;
      end
      attr_rd_q <= attr_mem[attr_idx];
      s3_char_q <= ch_shift;
      s3_moon_q <= moon;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s2_valid_q <= 1'b0;
      s3_valid_q <= 1'b0;
    end else if (adv) begin
      s1_valid_q <= in_fire;
      s2_valid_q <= s1_valid_q;
      s3_valid_q <= s2_valid_q && s2_mode_q == ltmcr_pkg::MODE_RENDER;
    end
  end

  assign out_valid_o          = s3_valid_q;
  assign out_item_o.char_code = s3_char_q;
  assign out_item_o.colour    = s3_moon_q ? cfg_i.moonlight_colour : attr_rd_q;

endmodule

// ===== sv/lit_tile_map_cell_renderer_core.sv =====
// ----------------------------------------------------------------------------
// lit_tile_map_cell_renderer_core
// Scrolled 4x4 tile map character renderer with per-cell light levels.
// ----------------------------------------------------------------------------
//  channel  | dir | handshake   | payload
//  in_if    | in  | valid/ready | mode, address, data, column, row
//  out_if   | out | valid/ready | char_code, colour
//  cfg      | in  | cfg_we_i    | cfg_idx_i, cfg_data_i
//
//  One item per cycle while the result register is not stalled; a render
//  result is registered through the map, tile and attribute memory reads
//  in that order. Write items give no result. The stores hold no reset state.
//  A stalled result register holds the whole pipeline.
// ----------------------------------------------------------------------------
module lit_tile_map_cell_renderer_core (
  input  logic              clk_i,
  input  logic              rst_ni,
  ltmcr_in_if.sink          in_if,
  ltmcr_out_if.source       out_if,
  input  logic              cfg_we_i,
  input  logic [1:0]        cfg_idx_i,
  input  logic [7:0]        cfg_data_i
);

  ltmcr_pkg::cfg_t    cfg_q;
  ltmcr_pkg::item_t   in_item;
  ltmcr_pkg::result_t out_item;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.scroll_x         <= 7'd0;
      cfg_q.scroll_y         <= 7'd0;
      cfg_q.moonlight_colour <= ltmcr_pkg::MOONLIGHT_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        ltmcr_pkg::REG_SCROLL_X:  cfg_q.scroll_x         <= cfg_data_i[6:0];
        ltmcr_pkg::REG_SCROLL_Y:  cfg_q.scroll_y         <= cfg_data_i[6:0];
        ltmcr_pkg::REG_MOONLIGHT: cfg_q.moonlight_colour <= cfg_data_i;
        default: begin
        end
      endcase
    end
  end

  assign in_item.mode    = in_if.mode;
  assign in_item.address = in_if.address;
  assign in_item.data    = in_if.data;
  assign in_item.column  = in_if.column;
  assign in_item.row     = in_if.row;

  ltmcr_pipe u_pipe (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .in_valid_i  (in_if.valid),
    .in_ready_o  (in_if.ready),
    .in_item_i   (in_item),
    .out_valid_o (out_if.valid),
    .out_ready_i (out_if.ready),
    .out_item_o  (out_item)
  );

  assign out_if.char_code = out_item.char_code;
  assign out_if.colour    = out_item.colour;

endmodule

// ===== sim/cell_render_checker.sv =====
// ----------------------------------------------------------------------------
// cell_render_checker
// Watches the item and result channels and the register port of the tile map
// cell renderer. Keeps its own copy of the four stores and the scroll and
// moonlight registers, works out the character and colour of every render
// item it sees accepted, and compares each accepted result with the oldest
// outstanding cell. Reports the number of outstanding cells and of failures.
// ----------------------------------------------------------------------------
module cell_render_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  ltmcr_in_if         in_if,
  ltmcr_out_if        out_if,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [7:0]  cfg_data_i,
  output int unsigned pending_o,
  output int unsigned errors_o
);
  import ltmcr_pkg::*;

  localparam int unsigned TILE_SIDE  = 4;
  localparam int unsigned TILE_CELLS = 16;
  localparam int unsigned ATTR_TABLE = 256;
  localparam int unsigned REPORT_MAX = 10;

  logic [7:0]  map_mem   [MAP_DEPTH];
  logic [7:0]  tile_mem  [TILE_DEPTH];
  logic [2:0]  light_mem [LIGHT_DEPTH];
  logic [7:0]  attr_mem  [ATTR_DEPTH];
  cfg_t        cfg;
  result_t     expected_cells[$];
  result_t     got;
  result_t     want;
  int unsigned mismatches;

  function automatic result_t shade_cell(input logic [5:0] column, input logic [4:0] row);
    int unsigned cx;
    int unsigned cy;
    int unsigned tile;
    int unsigned ch;
    int unsigned level;
    result_t     r;
    cx   = cfg.scroll_x + column;
    cy   = cfg.scroll_y + row;
    tile = map_mem[(((cy / TILE_SIDE) % MAP_HEIGHT) * MAP_WIDTH +
                    (cx / TILE_SIDE) % MAP_WIDTH) % MAP_DEPTH];
    ch   = tile_mem[(tile * TILE_CELLS + (cy % TILE_SIDE) * TILE_SIDE + cx % TILE_SIDE)
                    % TILE_DEPTH];
    if (cfg.scroll_x % TILE_SIDE == 0) begin
      level = light_mem[(row * SCREEN_COLUMNS + column) % LIGHT_DEPTH];
      if (level > MAX_LEVEL) begin
        level = MAX_LEVEL;
      end
      if (level == 0) begin
        r.colour = cfg.moonlight_colour;
      end else begin
        if (ch >= SHIFT_BASE) begin
          ch = (ch + level - 1) % ATTR_TABLE;
        end
        r.colour = attr_mem[((level - 1) * ATTR_TABLE + ch) % ATTR_DEPTH];
      end
    end else begin
      r.colour = attr_mem[int'(UNLIT_ATTR_SEL) * ATTR_TABLE + ch];
    end
    r.char_code = 8'(ch);
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg.scroll_x         = '0;
      cfg.scroll_y         = '0;
      cfg.moonlight_colour = MOONLIGHT_RST;
      expected_cells.delete();
      mismatches = 0;
      pending_o <= 0;
      errors_o  <= 0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          REG_SCROLL_X:  cfg.scroll_x = cfg_data_i[6:0];
          REG_SCROLL_Y:  cfg.scroll_y = cfg_data_i[6:0];
          REG_MOONLIGHT: cfg.moonlight_colour = cfg_data_i;
          default: ;
        endcase
      end
      if (out_if.valid && out_if.ready) begin
        got.char_code = out_if.char_code;
        got.colour    = out_if.colour;
        if (expected_cells.size() == 0) begin
          if (mismatches < REPORT_MAX) begin
            $display("unexpected result: char %02h colour %02h", got.char_code, got.colour);
          end
          mismatches++;
        end else begin
          want = expected_cells.pop_front();
          if (got.char_code !== want.char_code || got.colour !== want.colour) begin
            if (mismatches < REPORT_MAX) begin
              $display("cell differs: expected char %02h colour %02h, got char %02h colour %02h",
                       want.char_code, want.colour, got.char_code, got.colour);
            end
            mismatches++;
          end
        end
      end
      if (in_if.valid && in_if.ready) begin
        case (in_if.mode)
          MODE_RENDER: expected_cells.push_back(shade_cell(in_if.column, in_if.row));
          MODE_MAP:    map_mem[in_if.address % MAP_DEPTH] = in_if.data;
          MODE_TILE:   tile_mem[in_if.address] = in_if.data;
          MODE_LIGHT:  light_mem[in_if.address % LIGHT_DEPTH] = in_if.data[2:0];
          MODE_ATTR:   attr_mem[in_if.address % ATTR_DEPTH] = in_if.data;
          default: ;
        endcase
      end
      pending_o <= expected_cells.size();
      errors_o  <= mismatches;
    end
  end

endmodule

// ===== sim/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// Stimulus and verdict for the tile map cell renderer. Loads the stores with
// just the entries each render reads, mixes in stray writes and unknown modes,
// and steps through several scroll and moonlight settings. The sender works in
// bursts and the receiver stalls on its own pattern; a checker beside the
// block predicts and compares every result.
// ----------------------------------------------------------------------------
module tb;
  import ltmcr_pkg::*;

  localparam int unsigned SETTLE_CYCLES = 8;
  localparam int unsigned IDLE_LIMIT    = 2000;
  localparam int unsigned PHASES        = 8;
  localparam int unsigned PHASE_ITEMS   = 250;
  localparam int unsigned TILE_SIDE     = 4;
  localparam int unsigned TILE_CELLS    = 16;
  localparam int unsigned ATTR_TABLE    = 256;
  localparam logic [2:0]  MODE_TOP_CODE = '1;

  logic        clk_i    = 1'b0;
  logic        rst_ni   = 1'b0;
  logic        rx_ready = 1'b0;
  logic        cfg_we   = 1'b0;
  logic [1:0]  cfg_idx  = REG_SCROLL_X;
  logic [7:0]  cfg_data = '0;
  logic [9:0]  stall_cycle = '0;
  int unsigned pending;
  int unsigned errors;
  int unsigned idle_cycles;
  int unsigned items_sent;
  int unsigned burst_left;

  logic [7:0] map_img   [MAP_DEPTH];
  bit         map_set   [MAP_DEPTH];
  logic [7:0] tile_img  [TILE_DEPTH];
  bit         tile_set  [TILE_DEPTH];
  logic [2:0] light_img [LIGHT_DEPTH];
  bit         light_set [LIGHT_DEPTH];
  bit         attr_set  [ATTR_DEPTH];
  logic [6:0] scroll_x = '0;
  logic [6:0] scroll_y = '0;

  ltmcr_in_if  in_if ();
  ltmcr_out_if out_if ();

  assign out_if.ready = rx_ready;

  lit_tile_map_cell_renderer_core dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_if      (in_if),
    .out_if     (out_if),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data)
  );

  cell_render_checker cell_check (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_if      (in_if),
    .out_if     (out_if),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data),
    .pending_o  (pending),
    .errors_o   (errors)
  );

  always #2 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    stall_cycle <= stall_cycle + 1'b1;
    case (stall_cycle[9:8])
      2'd0:    rx_ready <= 1'b1;
      2'd1:    rx_ready <= 1'($urandom());
      2'd2:    rx_ready <= ($urandom_range(0, 3) == 0);
      default: rx_ready <= stall_cycle[3];
    endcase
  end

  always @(posedge clk_i) begin
    if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles == IDLE_LIMIT) begin
      $display("lit_tile_map_cell_renderer_core: mismatch");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  function automatic logic [11:0] aliased_addr(input int unsigned idx);
    return 12'(idx + MAP_DEPTH * $urandom_range(0, TILE_DEPTH / MAP_DEPTH - 1));
  endfunction

  task automatic send_item(input item_t it);
    int unsigned gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
      if (gap != 0) begin
        in_if.valid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      burst_left = $urandom_range(1, 24);
    end
    burst_left--;
    in_if.valid   <= 1'b1;
    in_if.mode    <= it.mode;
    in_if.address <= it.address;
    in_if.data    <= it.data;
    in_if.column  <= it.column;
    in_if.row     <= it.row;
    @(posedge clk_i);
    while (!in_if.ready) @(posedge clk_i);
    if (it.mode <= MODE_ATTR) begin
      items_sent++;
    end
  endtask

  task automatic hold_until_drained();
    in_if.valid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic load_regs(input logic [6:0] sx, input logic [6:0] sy, input logic [7:0] moon);
    hold_until_drained();
    cfg_we   <= 1'b1;
    cfg_idx  <= REG_SCROLL_X;
    cfg_data <= {1'($urandom()), sx};
    @(posedge clk_i);
    cfg_idx  <= REG_SCROLL_Y;
    cfg_data <= {1'($urandom()), sy};
    @(posedge clk_i);
    cfg_idx  <= REG_MOONLIGHT;
    cfg_data <= moon;
    @(posedge clk_i);
    cfg_we   <= 1'b0;
    scroll_x = sx;
    scroll_y = sy;
  endtask

  task automatic send_store(input mode_e m, input logic [11:0] addr, input logic [7:0] d);
    item_t it;
    case (m)
      MODE_MAP: begin
        map_img[addr % MAP_DEPTH] = d;
        map_set[addr % MAP_DEPTH] = 1'b1;
      end
      MODE_TILE: begin
        tile_img[addr] = d;
        tile_set[addr] = 1'b1;
      end
      MODE_LIGHT: begin
        light_img[addr % LIGHT_DEPTH] = d[2:0];
        light_set[addr % LIGHT_DEPTH] = 1'b1;
      end
      MODE_ATTR: attr_set[addr % ATTR_DEPTH] = 1'b1;
      default: ;
    endcase
    it.mode    = m;
    it.address = addr;
    it.data    = d;
    it.column  = 6'($urandom());
    it.row     = 5'($urandom());
    send_item(it);
  endtask

  // Write whatever the cell will read that is still unwritten, then render it.
  task automatic render_at(input logic [5:0] col, input logic [4:0] row,
                           input int tile_pick, input int char_pick, input int light_pick);
    int unsigned cx;
    int unsigned cy;
    int unsigned midx;
    int unsigned tidx;
    int unsigned lidx;
    int unsigned aidx;
    int unsigned level;
    bit          lit;
    logic [7:0]  ch;
    item_t       it;
    cx   = scroll_x + col;
    cy   = scroll_y + row;
    midx = (((cy / TILE_SIDE) % MAP_HEIGHT) * MAP_WIDTH + (cx / TILE_SIDE) % MAP_WIDTH)
           % MAP_DEPTH;
    if (!map_set[midx]) begin
      send_store(MODE_MAP, aliased_addr(midx), tile_pick < 0 ? 8'($urandom()) : 8'(tile_pick));
    end
    tidx = (map_img[midx] * TILE_CELLS + (cy % TILE_SIDE) * TILE_SIDE + cx % TILE_SIDE)
           % TILE_DEPTH;
    if (!tile_set[tidx]) begin
      if (char_pick >= 0) begin
        ch = 8'(char_pick);
      end else if ($urandom_range(0, 1) == 0) begin
        ch = 8'($urandom_range(SHIFT_BASE, 8'hFF));
      end else begin
        ch = 8'($urandom());
      end
      send_store(MODE_TILE, 12'(tidx), ch);
    end
    ch   = tile_img[tidx];
    lit  = 1'b1;
    aidx = int'(UNLIT_ATTR_SEL) * ATTR_TABLE + ch;
    if (scroll_x % TILE_SIDE == 0) begin
      lidx = (row * SCREEN_COLUMNS + col) % LIGHT_DEPTH;
      if (!light_set[lidx]) begin
        send_store(MODE_LIGHT, aliased_addr(lidx),
                   light_pick < 0 ? 8'($urandom()) : 8'(light_pick));
      end
      level = (light_img[lidx] > MAX_LEVEL) ? MAX_LEVEL : light_img[lidx];
      if (level == 0) begin
        lit = 1'b0;
      end else begin
        if (ch >= SHIFT_BASE) begin
          ch = ch + 8'(level - 1);
        end
        aidx = (level - 1) * ATTR_TABLE + ch;
      end
    end
    if (lit && !attr_set[aidx]) begin
      send_store(MODE_ATTR, aliased_addr(aidx), 8'($urandom()));
    end
    it.mode    = MODE_RENDER;
    it.address = 12'($urandom());
    it.data    = 8'($urandom());
    it.column  = col;
    it.row     = row;
    send_item(it);
  endtask

  task automatic send_unknown();
    item_t it;
    it.mode    = 3'($urandom_range(int'(MODE_ATTR) + 1, int'(MODE_TOP_CODE)));
    it.address = 12'($urandom());
    it.data    = 8'($urandom());
    it.column  = 6'($urandom());
    it.row     = 5'($urandom());
    send_item(it);
  endtask

  initial begin
    int unsigned pick;
    logic [6:0]  sx;
    logic [6:0]  sy;
    logic [7:0]  moon;
    logic [5:0]  col;
    logic [4:0]  row;
    in_if.valid   <= 1'b0;
    in_if.mode    <= MODE_RENDER;
    in_if.address <= '0;
    in_if.data    <= '0;
    in_if.column  <= '0;
    in_if.row     <= '0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // top char at saturated light wraps past zero
    render_at(6'd0, 5'd0, 255, 8'hFF, 8'hFF);
    // far corner outside the screen, level zero gives moonlight
    render_at(6'd63, 5'd31, 0, SHIFT_BASE, 8'h00);
    render_at(6'd39, 5'd23, 17, 8'h10, 8'hFA);
    render_at(6'd5, 5'd3, 1, 8'hC5, 8'h01);
    send_store(MODE_MAP, 12'hFFF, 8'h00);
    send_store(MODE_LIGHT, 12'hFFF, 8'hFD);
    send_store(MODE_ATTR, 12'hFFF, 8'hFF);
    send_unknown();
    send_unknown();
    send_unknown();
    load_regs(7'h7F, 7'h7F, 8'hFF);
    render_at(6'd0, 5'd0, -1, -1, -1);
    render_at(6'd39, 5'd23, -1, -1, -1);

    for (int phase = 0; phase < PHASES; phase++) begin
      case (phase)
        0: begin
          sx = '0;
          sy = '0;
          moon = '0;
        end
        1: begin
          sx = '1;
          sy = '1;
          moon = '1;
        end
        default: begin
          sx = 7'($urandom());
          if (phase % 2 == 0) begin
            sx[1:0] = 2'b00;
          end
          sy = 7'($urandom());
          moon = 8'($urandom());
        end
      endcase
      load_regs(sx, sy, moon);
      items_sent = 0;
      while (items_sent < PHASE_ITEMS) begin
        pick = $urandom_range(0, 99);
        if (pick < 70) begin
          col = ($urandom_range(0, 4) == 0) ? 6'($urandom())
                                             : 6'($urandom_range(0, SCREEN_COLUMNS - 1));
          row = ($urandom_range(0, 4) == 0) ? 5'($urandom())
                                             : 5'($urandom_range(0, SCREEN_ROWS - 1));
          render_at(col, row, -1, -1, -1);
        end else if (pick < 92) begin
          send_store(mode_e'($urandom_range(MODE_MAP, MODE_ATTR)), 12'($urandom()),
                     8'($urandom()));
        end else begin
          send_unknown();
        end
      end
    end

    hold_until_drained();
    if (errors == 0 && pending == 0) begin
      $display("lit_tile_map_cell_renderer_core: match");
    end else begin
      $display("lit_tile_map_cell_renderer_core: mismatch");
    end
    $finish;
  end

endmodule
